// ===== rtl/mpd_pkg.sv =====
// mouse packet deframer package: frame constants and the report record
// used by the frame collector and by the top level; no dependencies

package mpd_pkg;

  localparam logic [7:0] HEADER_BYTE  = 8'hAA;
  localparam int unsigned FRAME_LENGTH = 6;
  localparam logic [7:0] BUTTON_MASK  = 8'h07;
  localparam logic [7:0] WHEEL_FLAG   = 8'h08;

  localparam int unsigned POS_W = 3;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_LENGTH - 1);

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_SLOT = 1'b1
  } command_t;

  typedef struct packed {
    logic [7:0] wheel;
    logic [7:0] dy;
    logic [7:0] dx;
    logic [2:0] buttons;
  } report_t;

endpackage

// ===== rtl/mouse_packet_deframer.sv =====
// mouse packet deframer top level: frame collector plus registered
// result stage with a skid slot; depends on mpd_pkg and mpd_frame
//
//   channel | ports                                          | direction
//   in      | in_valid in_stall in_command in_data_byte      | item in
//           | in_host_enumerated                             |
//   out     | out_valid out_stall out_buttons out_delta_x    | item out
//           | out_delta_y out_wheel_delta                    |
//
// one item per cycle while in_stall is low; a report shows on out_
// the cycle after its slot item is accepted when the result register
// is free or taken that cycle; otherwise it waits in the skid slot
// rst_n is synchronous: clears frame position, pending flag, held report
// and both result slots
// in_stall is high exactly while the skid slot holds a report: it rises the
// cycle after a slot item meets a full result register held by out_stall,
// and falls the cycle after that register is taken

module mouse_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_data_byte,
  input  logic        in_host_enumerated,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_buttons,
  output logic signed [7:0] out_delta_x,
  output logic signed [7:0] out_delta_y,
  output logic signed [7:0] out_wheel_delta
);
  import mpd_pkg::*;

  logic    in_accept;
  logic    out_take;
  logic    res_valid;
  report_t res_report;
  logic    out_valid_r;
  report_t out_r;
  logic    skid_valid_r;
  report_t skid_r;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid && !skid_valid_r;
  assign out_take  = out_valid_r && !out_stall;

  mpd_frame u_frame (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (in_accept),
    .command         (in_command),
    .data_byte       (in_data_byte),
    .host_enumerated (in_host_enumerated),
    .res_valid       (res_valid),
    .res_report      (res_report)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_take) begin
          out_r        <= skid_r;
          skid_valid_r <= 1'b0;
        end
      end else if (res_valid) begin
        if (!out_valid_r || out_take) begin
          out_r       <= res_report;
          out_valid_r <= 1'b1;
        end else begin
          skid_r       <= res_report;
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_buttons     = out_r.buttons;
  assign out_delta_x     = out_r.dx;
  assign out_delta_y     = out_r.dy;
  assign out_wheel_delta = out_r.wheel;

  // skid slot only fills behind a full result register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid slot holds a report with the result register empty");

  // a byte item never disturbs a waiting result
  a_byte_keeps_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_command == CMD_BYTE) && out_valid_r && out_stall)
      |=> (out_valid_r && !skid_valid_r && $stable(out_r)))
    else $error("byte item changed a stalled result");

  // a taken result with nothing behind it empties the register
  a_out_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (out_take && !skid_valid_r && !res_valid) |=> !out_valid_r)
    else $error("result register did not empty after hand-off");

endmodule

// ===== rtl/mpd_frame.sv =====
// frame collector: header hunt, byte capture, checksum check and
// pending/held report registers; depends on mpd_pkg

module mpd_frame (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic             command,
  input  logic [7:0]       data_byte,
  input  logic             host_enumerated,
  output logic             res_valid,
  output mpd_pkg::report_t res_report
);
  import mpd_pkg::*;

  logic [POS_W-1:0] pos_r, pos_nxt;
  // frame bytes 1..4; byte 0 is always the header
  logic [7:0]       body_r [1:4];
  logic             pend_valid_r, pend_valid_nxt;
  report_t          pend_r;
  report_t          held_r, held_nxt;
  logic [7:0]       sum;
  logic             is_byte;
  logic             is_slot;
  logic             check_ok;
  report_t          frame_rep;

  assign is_byte = accept && (command == CMD_BYTE);
  assign is_slot = accept && (command == CMD_SLOT) && host_enumerated;

  assign sum = HEADER_BYTE ^ body_r[1] ^ body_r[2] ^ body_r[3] ^ body_r[4];
  assign check_ok = is_byte && (pos_r == POS_LAST) && (sum == data_byte);

  always_comb begin
    frame_rep.buttons = body_r[1][2:0] & BUTTON_MASK[2:0];
    frame_rep.dx      = body_r[2];
    frame_rep.dy      = body_r[3];
    frame_rep.wheel   = ((body_r[1] & WHEEL_FLAG) != 8'h00) ? body_r[4] : 8'h00;
  end

  always_comb begin
    pos_nxt = pos_r;
    if (is_byte) begin
      priority if (pos_r == '0) begin
        pos_nxt = (data_byte == HEADER_BYTE) ? POS_W'(1) : '0;
      end else if (pos_r < POS_LAST) begin
        pos_nxt = pos_r + POS_W'(1);
      end else begin
        pos_nxt = '0;
      end
    end
  end

  always_comb begin
    pend_valid_nxt = pend_valid_r;
    held_nxt       = held_r;
    if (check_ok) begin
      pend_valid_nxt = 1'b1;
    end else if (is_slot) begin
      pend_valid_nxt = 1'b0;
      if (pend_valid_r) begin
        held_nxt = pend_r;
      end
    end
  end

  assign res_valid  = is_slot;
  assign res_report = held_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      pend_valid_r <= 1'b0;
      held_r       <= '0;
    end else begin
      pos_r        <= pos_nxt;
      pend_valid_r <= pend_valid_nxt;
      held_r       <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (is_byte && (pos_r != '0) && (pos_r < POS_LAST)) begin
      body_r[pos_r] <= data_byte;
    end
    if (check_ok) begin
      pend_r <= frame_rep;
    end
  end

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for mouse_packet_deframer: random and directed byte
// and report-slot items with a report predictor and scoreboard
// depends on mpd_pkg and the mouse_packet_deframer rtl

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mpd_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int RANDOM_ITEMS = 2000;
  localparam int HOLD_CYCLES = 400;

  class report_scoreboard;
    logic [2:0] frame_pos;
    logic [7:0] frame_buf [5];
    bit         pend_valid;
    report_t    pend_report;
    report_t    held_report;
    report_t    report_queue [$];
    int         mismatches;

    function new();
      frame_pos   = '0;
      foreach (frame_buf[i]) frame_buf[i] = '0;
      pend_valid  = 1'b0;
      pend_report = '0;
      held_report = '0;
      mismatches  = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      logic [7:0] sum;
      if (frame_pos == 0) begin
        if (b == HEADER_BYTE) begin
          frame_buf[0] = b;
          frame_pos = 3'd1;
        end
      end else if (frame_pos < POS_LAST) begin
        frame_buf[frame_pos] = b;
        frame_pos = frame_pos + 3'd1;
      end else if (frame_pos == POS_LAST) begin
        sum = frame_buf[0] ^ frame_buf[1] ^ frame_buf[2] ^ frame_buf[3] ^ frame_buf[4];
        if (sum == b) begin
          pend_report.buttons = 3'(frame_buf[1] & BUTTON_MASK);
          pend_report.dx      = frame_buf[2];
          pend_report.dy      = frame_buf[3];
          pend_report.wheel   = ((frame_buf[1] & WHEEL_FLAG) != 0) ? frame_buf[4] : 8'h00;
          pend_valid = 1'b1;
        end
        frame_pos = '0;
      end else begin
        frame_pos = '0;
      end
    endfunction

    function void note_item(command_t cmd, logic [7:0] data, logic enumerated);
      if (cmd == CMD_BYTE) begin
        take_byte(data);
      end else if (enumerated) begin
        if (pend_valid) begin
          held_report = pend_report;
          pend_valid = 1'b0;
        end
        report_queue.push_back(held_report);
      end
    endfunction

    function void check_report(logic [2:0] buttons, logic [7:0] dx, logic [7:0] dy,
                               logic [7:0] wheel);
      report_t want;
      if (report_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected report buttons=%h dx=%h dy=%h wheel=%h",
                   $realtime, buttons, dx, dy, wheel);
        return;
      end
      want = report_queue.pop_front();
      if (buttons !== want.buttons || dx !== want.dx || dy !== want.dy ||
          wheel !== want.wheel) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: report mismatch expected b=%h dx=%h dy=%h w=%h got b=%h dx=%h dy=%h w=%h",
                   $realtime, want.buttons, want.dx, want.dy, want.wheel,
                   buttons, dx, dy, wheel);
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_command;
  logic [7:0]  in_data_byte;
  logic        in_host_enumerated;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_buttons;
  logic signed [7:0] out_delta_x;
  logic signed [7:0] out_delta_y;
  logic signed [7:0] out_wheel_delta;

  report_scoreboard sb;
  int  items_sent;
  int  burst_left;
  int  idle_count;
  bit  hold_req;
  bit  hold_done;

  mouse_packet_deframer DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_data_byte       (in_data_byte),
    .in_host_enumerated (in_host_enumerated),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_buttons        (out_buttons),
    .out_delta_x        (out_delta_x),
    .out_delta_y        (out_delta_y),
    .out_wheel_delta    (out_wheel_delta)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(input command_t cmd, input logic [7:0] data,
                           input logic enumerated);
    int gap;
    @(negedge clk);
    in_valid           <= 1'b1;
    in_command         <= cmd;
    in_data_byte       <= data;
    in_host_enumerated <= enumerated;
    do @(posedge clk); while (in_stall);
    sb.note_item(cmd, data, enumerated);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        in_valid           <= 1'b0;
        in_command         <= 1'($urandom_range(0, 1));
        in_data_byte       <= 8'($urandom);
        in_host_enumerated <= 1'($urandom_range(0, 1));
        @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(CMD_BYTE, b, 1'($urandom_range(0, 1)));
  endtask

  task automatic send_slot(input logic enumerated);
    send_item(CMD_SLOT, 8'($urandom), enumerated);
  endtask

  // slots may be slipped in between frame bytes; they leave the frame position alone
  task automatic send_frame(input logic [7:0] flags, input logic [7:0] dx,
                            input logic [7:0] dy, input logic [7:0] wheel,
                            input bit corrupt, input int slot_pct);
    logic [7:0] frame [6];
    frame[0] = HEADER_BYTE;
    frame[1] = flags;
    frame[2] = dx;
    frame[3] = dy;
    frame[4] = wheel;
    frame[5] = HEADER_BYTE ^ flags ^ dx ^ dy ^ wheel;
    if (corrupt) frame[5] = frame[5] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < 6; i++) begin
      if (i > 0 && $urandom_range(0, 99) < slot_pct)
        send_slot($urandom_range(0, 9) < 8);
      send_byte(frame[i]);
    end
  endtask

  // result side: random stall patterns plus one long hold-off
  initial begin
    int mode;
    int len;
    int phase;
    out_stall = 1'b0;
    phase = 0;
    forever begin
      if (hold_req && !hold_done) begin
        repeat (HOLD_CYCLES) begin
          @(negedge clk);
          out_stall <= 1'b1;
        end
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 80);
      repeat (len) begin
        @(negedge clk);
        phase++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= 1'($urandom_range(0, 1));
          2: out_stall <= (phase % 3) == 0;
          default: out_stall <= $urandom_range(0, 3) == 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_report(out_buttons, out_delta_x, out_delta_y, out_wheel_delta);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count >= IDLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    int pick;
    int n;
    sb = new();
    rst_n              = 1'b0;
    in_valid           = 1'b0;
    in_command         = 1'b0;
    in_data_byte       = 8'h00;
    in_host_enumerated = 1'b0;
    items_sent = 0;
    idle_count = 0;
    burst_left = $urandom_range(1, 40);
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty held report, slot without host, noise while hunting,
    // extreme fields, header byte as data, bad checksum keeps pending report
    send_slot(1'b1);
    send_slot(1'b0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'h0F, 8'h80, 8'h7F, 8'hFF, 1'b0, 0);
    send_slot(1'b0);
    send_slot(1'b1);
    send_frame(8'h02, HEADER_BYTE, 8'h00, 8'h7F, 1'b0, 0);
    send_frame(8'hFF, 8'h01, 8'h80, 8'h80, 1'b1, 0);
    send_slot(1'b1);

    while (items_sent < RANDOM_ITEMS + 25) begin
      if (!hold_req && items_sent >= RANDOM_ITEMS / 2) begin
        hold_req = 1'b1;
        repeat (8) send_slot(1'b1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, 10);
      end else if (pick < 65) begin
        send_frame(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 1'b1, 10);
      end else if (pick < 82) begin
        n = $urandom_range(1, 3);
        repeat (n) send_slot(1'b1);
      end else if (pick < 92) begin
        n = $urandom_range(1, 4);
        repeat (n) send_byte(8'($urandom));
      end else begin
        send_slot(1'b0);
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.report_queue.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (sb.mismatches == 0 && sb.report_queue.size() == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
